// ===== hw/rtl/lzo_pkg.sv =====
// Shared types, constants and helpers for the LZO1X stream decompressor
package lzo_pkg;

  localparam int unsigned WindowSize = 65536;
  localparam int unsigned WinAw      = $clog2(WindowSize);
  localparam int unsigned LenBits    = 32;
  localparam int unsigned QDepth     = 2;

  localparam logic [LenBits-1:0] LenMax = {LenBits{1'b1}};

  typedef enum logic [3:0] {
    PH_FIRST       = 4'd0,
    PH_TOKEN       = 4'd1,
    PH_TOKEN_LIT   = 4'd2,
    PH_TOKEN_MATCH = 4'd3,
    PH_LIT_EXT     = 4'd4,
    PH_LITERALS    = 4'd5,
    PH_TRAIL       = 4'd6,
    PH_D1_M2       = 4'd7,
    PH_D1_SHORT2   = 4'd8,
    PH_D1_SHORT3   = 4'd9,
    PH_M_EXT       = 4'd10,
    PH_D2_LO       = 4'd11,
    PH_D2_HI       = 4'd12,
    PH_COPY        = 4'd13
  } phase_e;

  typedef enum logic [2:0] {
    ST_RUNNING  = 3'd0,
    ST_DONE     = 3'd1,
    ST_LOOKBACK = 3'd2,
    ST_OVERRUN  = 3'd3,
    ST_SHORT    = 3'd4,
    ST_TRAILING = 3'd5
  } status_e;

  typedef enum logic {
    FN_BYTE  = 1'b0,
    FN_DRAIN = 1'b1
  } func_e;

  localparam logic [1:0] RegOutputLimit = 2'd0;

  // One queued request between the front and the back
  typedef struct packed {
    func_e      func;
    logic [7:0] in_byte;
    logic       in_last;
  } req_t;

  // Saturating add of two lengths
  function automatic logic [LenBits-1:0] sat_add(input logic [LenBits-1:0] a,
                                                 input logic [LenBits-1:0] b);
    logic [LenBits:0] s;
    s = {1'b0, a} + {1'b0, b};
    sat_add = s[LenBits] ? LenMax : s[LenBits-1:0];
  endfunction

endpackage

// ===== hw/rtl/lzo1x_stream_decompressor_top.sv =====
// Top level of the LZO1X stream decompressor: APB register, front and back
//
//  channel | direction | handshake          | payload
//  in      | input     | in_valid_i/stall_o | func_i, in_byte_i, in_last_i
//  out     | output    | out_valid_o/stall_i| res_out_valid_o .. produced_total_o
//  apb     | input     | psel/penable       | output_limit at address 0
//
// One request a cycle while the output does not stall; a request is held in a queue
// entry and then the output register. A copy's first byte is read from the history
// RAM in the cycle the copy is queued, so drains follow with no gap.
// The history RAM has one write port and one read port, read data registered.
// Reset clears all control state; history needs no clearing.
// Either side may stall; a two-entry queue and the output register decouple them.
module lzo1x_stream_decompressor_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        func_i,
  input  logic [7:0]  in_byte_i,
  input  logic        in_last_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        res_out_valid_o,
  output logic [7:0]  out_byte_o,
  output logic [2:0]  status_o,
  output logic        copy_pending_o,
  output logic [31:0] produced_total_o
);

  logic [31:0]   limit_q;
  lzo_pkg::req_t req, q_req;
  logic          q_valid, q_take;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == lzo_pkg::RegOutputLimit[0]) ? limit_q : 32'd0;

  // Write the limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= 32'd65536;
    end else if (psel && penable && pwrite && paddr[2] == lzo_pkg::RegOutputLimit[0]) begin
      limit_q <= pwdata;
    end
  end

  assign req.func    = lzo_pkg::func_e'(func_i);
  assign req.in_byte = in_byte_i;
  assign req.in_last = in_last_i;

  lzo_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o,
    .req_i(req), .q_valid_o(q_valid), .q_take_i(q_take), .q_req_o(q_req)
  );

  lzo_back u_back (
    .clk_i, .rst_ni, .limit_i(limit_q),
    .q_valid_i(q_valid), .q_take_o(q_take), .q_req_i(q_req),
    .out_valid_o, .out_stall_i,
    .res_valid_o(res_out_valid_o), .res_byte_o(out_byte_o),
    .res_status_o(status_o), .res_pending_o(copy_pending_o),
    .res_total_o(produced_total_o)
  );

endmodule

// ===== hw/rtl/lzo_front.sv =====
// Front: accepts requests into a short queue and hands them to the back
module lzo_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  lzo_pkg::req_t req_i,
  output logic          q_valid_o,
  input  logic          q_take_i,
  output lzo_pkg::req_t q_req_o
);

  localparam int unsigned PtrW = $clog2(lzo_pkg::QDepth);

  lzo_pkg::req_t            mem_q [lzo_pkg::QDepth];
  logic [PtrW-1:0]          wp_q, rp_q;
  logic [PtrW:0]            cnt_q;
  logic                     push, pop;

  assign in_stall_o = (cnt_q == (PtrW+1)'(lzo_pkg::QDepth));
  assign push       = in_valid_i && !in_stall_o;
  assign q_valid_o  = (cnt_q != '0);
  assign pop        = q_valid_o && q_take_i;
  assign q_req_o    = mem_q[rp_q];

  // Store request
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wp_q] <= req_i;
    end
  end

  // Advance pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wp_q <= wp_q + PtrW'(1);
      if (pop)  rp_q <= rp_q + PtrW'(1);
      cnt_q <= cnt_q + (PtrW+1)'(push) - (PtrW+1)'(pop);
    end
  end

endmodule

// ===== hw/rtl/lzo_back.sv =====
// Back: decodes one request per cycle against the history window while the output is free
module lzo_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [31:0]   limit_i,
  input  logic          q_valid_i,
  output logic          q_take_o,
  input  lzo_pkg::req_t q_req_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output logic          res_valid_o,
  output logic [7:0]    res_byte_o,
  output logic [2:0]    res_status_o,
  output logic          res_pending_o,
  output logic [31:0]   res_total_o
);

  localparam int unsigned Lb = lzo_pkg::LenBits;
  localparam int unsigned Aw = lzo_pkg::WinAw;

  logic [7:0]          hist_q [lzo_pkg::WindowSize];
  logic [31:0]         prod_q, prod_d;
  lzo_pkg::phase_e     ph_q, ph_d;
  logic [Lb-1:0]       run_q, run_d;
  logic [15:0]         dist_q, dist_d;
  logic [7:0]          tok_q, tok_d;
  logic [1:0]          trail_q, trail_d;
  lzo_pkg::status_e    st_q, st_d;
  // Prefetched copy byte and its valid flag
  logic [7:0]          rd_q;
  logic                rd_ok_q, rd_ok_d;
  // Output stage
  logic                ov_q;
  logic                rv_q, rv_d;
  logic [7:0]          rb_q, rb_d;
  logic                wr_en;
  logic [Aw-1:0]       wr_addr, rd_addr;
  logic                take;

  // Take a request when the output stage is free and, for a drain, a copy byte is ready
  logic copy_wait;
  assign copy_wait = (ph_q == lzo_pkg::PH_COPY) && !rd_ok_q &&
                     (st_q == lzo_pkg::ST_RUNNING) &&
                     (q_req_i.func == lzo_pkg::FN_DRAIN);
  assign take     = q_valid_i && (!ov_q || !out_stall_i) && !copy_wait;
  assign q_take_o = take;

  // Length checks against the limit
  function automatic logic too_long(input logic [Lb-1:0] c, input logic [31:0] p,
                                    input logic [31:0] lim);
    logic [32:0] s;
    s = {1'b0, p} + 33'(c);
    too_long = (c == lzo_pkg::LenMax) || (s > {1'b0, lim});
  endfunction

  // Decode one request
  always_comb begin
    logic [7:0]  b;
    logic [4:0]  t;
    logic [15:0] v;
    logic [Lb-1:0] ln;
    logic [16:0] dd;
    logic        qm;
    logic [15:0] qd;
    logic [Lb-1:0] ql;
    logic [1:0]  qt;
    prod_d  = prod_q;
    ph_d    = ph_q;
    run_d   = run_q;
    dist_d  = dist_q;
    tok_d   = tok_q;
    trail_d = trail_q;
    st_d    = st_q;
    rv_d    = 1'b0;
    rb_d    = 8'd0;
    wr_en   = 1'b0;
    b       = q_req_i.in_byte;
    t       = '0;
    v       = '0;
    ln      = '0;
    dd      = '0;
    qm      = 1'b0;
    qd      = '0;
    ql      = '0;
    qt      = '0;
    if (take) begin
      if (st_q != lzo_pkg::ST_RUNNING) begin
        if (q_req_i.func == lzo_pkg::FN_BYTE &&
            (st_q == lzo_pkg::ST_DONE || st_q == lzo_pkg::ST_TRAILING)) begin
          st_d = lzo_pkg::ST_TRAILING;
        end
      end else if (q_req_i.func == lzo_pkg::FN_DRAIN) begin
        if (ph_q == lzo_pkg::PH_COPY) begin
          wr_en  = 1'b1;
          rv_d   = 1'b1;
          rb_d   = rd_q;
          prod_d = prod_q + 32'd1;
          run_d  = run_q - Lb'(1);
          if (run_q == Lb'(1)) begin
            if (trail_q == 2'd0) ph_d = lzo_pkg::PH_TOKEN;
            else if (too_long(Lb'(trail_q), prod_d, limit_i)) st_d = lzo_pkg::ST_OVERRUN;
            else ph_d = lzo_pkg::PH_TRAIL;
          end
        end
      end else if (ph_q != lzo_pkg::PH_COPY) begin
        unique case (ph_q)
          lzo_pkg::PH_FIRST, lzo_pkg::PH_TOKEN, lzo_pkg::PH_TOKEN_LIT,
          lzo_pkg::PH_TOKEN_MATCH: begin
            if (ph_q == lzo_pkg::PH_FIRST && b > 8'd17) begin
              ln = Lb'(b - 8'd17);
              if (ln >= Lb'(4)) begin
                if (too_long(ln, prod_q, limit_i)) st_d = lzo_pkg::ST_OVERRUN;
                else begin run_d = ln; ph_d = lzo_pkg::PH_LITERALS; end
              end else if (too_long(ln, prod_q, limit_i)) begin
                st_d = lzo_pkg::ST_OVERRUN;
              end else begin
                trail_d = ln[1:0];
                ph_d    = lzo_pkg::PH_TRAIL;
              end
            end else begin
              tok_d = b;
              if (b >= 8'd64) begin
                ph_d = lzo_pkg::PH_D1_M2;
              end else if (b >= 8'd16) begin
                t     = (b >= 8'd32) ? b[4:0] : {2'b00, b[2:0]};
                run_d = (t == 5'd0) ? '0 : Lb'(t) + Lb'(2);
                ph_d  = (t == 5'd0) ? lzo_pkg::PH_M_EXT : lzo_pkg::PH_D2_LO;
              end else if (ph_q == lzo_pkg::PH_TOKEN_LIT) begin
                ph_d = lzo_pkg::PH_D1_SHORT3;
              end else if (ph_q == lzo_pkg::PH_TOKEN_MATCH) begin
                ph_d = lzo_pkg::PH_D1_SHORT2;
              end else if (b == 8'd0) begin
                run_d = '0;
                ph_d  = lzo_pkg::PH_LIT_EXT;
              end else begin
                ln = Lb'(b) + Lb'(3);
                if (too_long(ln, prod_q, limit_i)) st_d = lzo_pkg::ST_OVERRUN;
                else begin run_d = ln; ph_d = lzo_pkg::PH_LITERALS; end
              end
            end
          end
          lzo_pkg::PH_LIT_EXT: begin
            if (b == 8'd0) begin
              run_d = lzo_pkg::sat_add(run_q, Lb'(255));
            end else begin
              ln = lzo_pkg::sat_add(run_q, Lb'(b) + Lb'(18));
              if (too_long(ln, prod_q, limit_i)) st_d = lzo_pkg::ST_OVERRUN;
              else begin run_d = ln; ph_d = lzo_pkg::PH_LITERALS; end
            end
          end
          lzo_pkg::PH_LITERALS: begin
            wr_en  = 1'b1;
            rv_d   = 1'b1;
            rb_d   = b;
            prod_d = prod_q + 32'd1;
            run_d  = run_q - Lb'(1);
            if (run_q == Lb'(1)) ph_d = lzo_pkg::PH_TOKEN_LIT;
          end
          lzo_pkg::PH_TRAIL: begin
            wr_en   = 1'b1;
            rv_d    = 1'b1;
            rb_d    = b;
            prod_d  = prod_q + 32'd1;
            trail_d = trail_q - 2'd1;
            if (trail_q == 2'd1) ph_d = lzo_pkg::PH_TOKEN_MATCH;
          end
          lzo_pkg::PH_D1_M2: begin
            qm = 1'b1;
            dd = 17'd1 + 17'(tok_q[4:2]) + {6'd0, b, 3'd0};
            ql = Lb'(tok_q[7:5]) + Lb'(1);
            qt = tok_q[1:0];
          end
          lzo_pkg::PH_D1_SHORT2: begin
            qm = 1'b1;
            dd = 17'd1 + 17'(tok_q[7:2]) + {7'd0, b, 2'd0};
            ql = Lb'(2);
            qt = tok_q[1:0];
          end
          lzo_pkg::PH_D1_SHORT3: begin
            qm = 1'b1;
            dd = 17'h801 + 17'(tok_q[7:2]) + {7'd0, b, 2'd0};
            ql = Lb'(3);
            qt = tok_q[1:0];
          end
          lzo_pkg::PH_M_EXT: begin
            if (b == 8'd0) begin
              run_d = lzo_pkg::sat_add(run_q, Lb'(255));
            end else begin
              run_d = lzo_pkg::sat_add(run_q,
                        ((tok_q >= 8'd32) ? Lb'(31) : Lb'(7)) + Lb'(b) + Lb'(2));
              ph_d  = lzo_pkg::PH_D2_LO;
            end
          end
          lzo_pkg::PH_D2_LO: begin
            dist_d = {8'd0, b};
            ph_d   = lzo_pkg::PH_D2_HI;
          end
          lzo_pkg::PH_D2_HI: begin
            v = {2'b00, b, dist_q[7:2]};
            if (tok_q >= 8'd32) begin
              qm = 1'b1;
              dd = 17'd1 + 17'(v);
              ql = run_q;
              qt = dist_q[1:0];
            end else if (!tok_q[3] && v == 16'd0) begin
              st_d = lzo_pkg::ST_DONE;
            end else begin
              qm = 1'b1;
              dd = 17'h4000 + 17'({tok_q[3], 14'd0}) + 17'(v);
              ql = run_q;
              qt = dist_q[1:0];
            end
          end
          default: ;
        endcase
        // Queue a back-reference copy, or stop on a bad distance or an overlong match
        if (qm) begin
          if (32'(dd) > prod_q) st_d = lzo_pkg::ST_LOOKBACK;
          else if (too_long(ql, prod_q, limit_i)) st_d = lzo_pkg::ST_OVERRUN;
          else begin
            qd      = dd[15:0];
            dist_d  = qd;
            run_d   = ql;
            trail_d = qt;
            ph_d    = lzo_pkg::PH_COPY;
          end
        end
        if (q_req_i.in_last && st_d == lzo_pkg::ST_RUNNING) st_d = lzo_pkg::ST_SHORT;
      end
    end
  end

  assign wr_addr = prod_q[Aw-1:0];
  // Read the next copy byte; a just-written byte is forwarded
  assign rd_addr = prod_d[Aw-1:0] - Aw'(dist_d);
  assign rd_ok_d = (ph_d == lzo_pkg::PH_COPY);

  // History window
  always_ff @(posedge clk_i) begin
    if (wr_en) hist_q[wr_addr] <= rb_d;
    if (wr_en && rd_addr == wr_addr) rd_q <= rb_d;
    else rd_q <= hist_q[rd_addr];
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_q  <= '0;
      ph_q    <= lzo_pkg::PH_FIRST;
      run_q   <= '0;
      dist_q  <= '0;
      tok_q   <= '0;
      trail_q <= '0;
      st_q    <= lzo_pkg::ST_RUNNING;
      rd_ok_q <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      rd_ok_q <= rd_ok_d;
      if (take) begin
        prod_q  <= prod_d;
        ph_q    <= ph_d;
        run_q   <= run_d;
        dist_q  <= dist_d;
        tok_q   <= tok_d;
        trail_q <= trail_d;
        st_q    <= st_d;
        ov_q    <= 1'b1;
      end else if (!out_stall_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (take) begin
      rv_q <= rv_d;
      rb_q <= rb_d;
    end
  end

  assign out_valid_o   = ov_q;
  assign res_valid_o   = rv_q;
  assign res_byte_o    = rb_q;
  assign res_status_o  = st_q;
  assign res_pending_o = (st_q == lzo_pkg::ST_RUNNING) && (ph_q == lzo_pkg::PH_COPY);
  assign res_total_o   = prod_q;

endmodule

// ===== hw/rtl/lzo_checker.sv =====
// Port checker for the decompressor, bound to the top level
module lzo_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic       res_out_valid_o,
  input logic [7:0] out_byte_o,
  input logic [2:0] status_o,
  input logic       copy_pending_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_byte_o))
    else $error("stalled result changed");

  a_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && copy_pending_o |-> status_o == 3'd0)
    else $error("copy pending after stop");

  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !res_out_valid_o |-> out_byte_o == 8'd0)
    else $error("byte without valid");

endmodule

bind lzo1x_stream_decompressor_top lzo_checker u_chk (.*);

// ===== tb/lzo1x_stream_decompressor_top_test.sv =====
// Self-checking testbench for the LZO1X stream decompressor top level
`timescale 1ns / 1ps

module lzo1x_stream_decompressor_top_test;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned ItemsPerPhase = 145;
  localparam longint unsigned LenSat = 64'hFFFF_FFFF;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    lzo_pkg::status_e status;
    logic       pending;
    logic [31:0] total;
  } decoded_t;

  typedef struct packed {
    lzo_pkg::func_e fn;
    logic [7:0] data;
    logic       last;
    logic       typed;
    decoded_t   want;
  } stim_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        psel, penable, pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic        pready;
  logic        in_valid_i, in_stall_o;
  logic        func_i;
  logic [7:0]  in_byte_i;
  logic        in_last_i;
  logic        out_valid_o, out_stall_i;
  logic        res_out_valid_o;
  logic [7:0]  out_byte_o;
  logic [2:0]  status_o;
  logic        copy_pending_o;
  logic [31:0] produced_total_o;

  lzo1x_stream_decompressor_top u_dut (.*);

  // Decoder state mirrored by the predictor
  logic [7:0]      dec_hist [lzo_pkg::WindowSize];
  logic [31:0]     dec_limit;
  logic [31:0]     dec_produced;
  lzo_pkg::phase_e dec_phase;
  longint unsigned dec_run;
  int unsigned     dec_dist;
  logic [7:0]      dec_token;
  logic [1:0]      dec_trail;
  lzo_pkg::status_e dec_outcome;

  decoded_t    decoded_q[$];
  int unsigned mismatches;
  int unsigned cycles;
  int unsigned send_idle_pct;
  int unsigned stall_pct;
  logic [7:0]  planned_hi;

  // Directed requests: after reset with a limit of one, then short, M2, literal and M3 tokens
  stim_row_t head_rows [2] = '{
    '{lzo_pkg::FN_BYTE, 8'd18, 1'b0, 1'b1,
      '{1'b0, 8'h00, lzo_pkg::ST_RUNNING, 1'b0, 32'd0}},
    '{lzo_pkg::FN_BYTE, 8'hFF, 1'b0, 1'b1,
      '{1'b1, 8'hFF, lzo_pkg::ST_RUNNING, 1'b0, 32'd1}}
  };
  stim_row_t body_rows [24] = '{
    '{lzo_pkg::FN_DRAIN, 8'h00, 1'b0, 1'b1,
      '{1'b0, 8'h00, lzo_pkg::ST_RUNNING, 1'b0, 32'd1}},
    '{lzo_pkg::FN_BYTE,  8'h01, 1'b0, 1'b0, '0},
    '{lzo_pkg::FN_BYTE,  8'h00, 1'b0, 1'b1,
      '{1'b0, 8'h00, lzo_pkg::ST_RUNNING, 1'b1, 32'd1}},
    '{lzo_pkg::FN_BYTE,  8'hAA, 1'b1, 1'b1,
      '{1'b0, 8'h00, lzo_pkg::ST_RUNNING, 1'b1, 32'd1}},
    '{lzo_pkg::FN_DRAIN, 8'h00, 1'b0, 1'b1,
      '{1'b1, 8'hFF, lzo_pkg::ST_RUNNING, 1'b1, 32'd2}},
    '{lzo_pkg::FN_DRAIN, 8'h00, 1'b0, 1'b1,
      '{1'b1, 8'hFF, lzo_pkg::ST_RUNNING, 1'b0, 32'd3}},
    '{lzo_pkg::FN_BYTE,  8'h00, 1'b0, 1'b0, '0},
    '{lzo_pkg::FN_BYTE,  8'h40, 1'b0, 1'b0, '0},
    '{lzo_pkg::FN_BYTE,  8'h00, 1'b0, 1'b0, '0},
    '{lzo_pkg::FN_DRAIN, 8'h00, 1'b0, 1'b0, '0},
    '{lzo_pkg::FN_DRAIN, 8'h00, 1'b0, 1'b0, '0},
    '{lzo_pkg::FN_DRAIN, 8'h00, 1'b0, 1'b0, '0},
    '{lzo_pkg::FN_BYTE,  8'h01, 1'b0, 1'b0, '0},
    '{lzo_pkg::FN_BYTE,  8'h00, 1'b0, 1'b0, '0},
    '{lzo_pkg::FN_BYTE,  8'h80, 1'b0, 1'b0, '0},
    '{lzo_pkg::FN_BYTE,  8'h7F, 1'b0, 1'b0, '0},
    '{lzo_pkg::FN_BYTE,  8'hFF, 1'b0, 1'b0, '0},
    '{lzo_pkg::FN_BYTE,  8'h21, 1'b0, 1'b0, '0},
    '{lzo_pkg::FN_BYTE,  8'h04, 1'b0, 1'b0, '0},
    '{lzo_pkg::FN_BYTE,  8'h00, 1'b0, 1'b0, '0},
    '{lzo_pkg::FN_DRAIN, 8'h00, 1'b0, 1'b0, '0},
    '{lzo_pkg::FN_DRAIN, 8'h00, 1'b0, 1'b0, '0},
    '{lzo_pkg::FN_DRAIN, 8'h00, 1'b0, 1'b0, '0},
    '{lzo_pkg::FN_DRAIN, 8'h00, 1'b0, 1'b0, '0}
  };

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Predictor
  function automatic logic run_too_long(longint unsigned count);
    return count >= LenSat ||
           longint'(dec_produced) + count > longint'(dec_limit);
  endfunction

  function automatic longint unsigned sat_len(longint unsigned v);
    return v > LenSat ? LenSat : v;
  endfunction

  function automatic void emit_byte(logic [7:0] b, inout decoded_t r);
    dec_hist[dec_produced[15:0]] = b;
    dec_produced++;
    r.valid = 1'b1;
    r.data  = b;
  endfunction

  function automatic void open_literals(longint unsigned count);
    if (run_too_long(count)) begin
      dec_outcome = lzo_pkg::ST_OVERRUN;
    end else begin
      dec_run   = count;
      dec_phase = lzo_pkg::PH_LITERALS;
    end
  endfunction

  function automatic void open_copy(int unsigned distance, longint unsigned len,
                                    logic [7:0] trail);
    if (distance > dec_produced) begin
      dec_outcome = lzo_pkg::ST_LOOKBACK;
    end else if (run_too_long(len)) begin
      dec_outcome = lzo_pkg::ST_OVERRUN;
    end else begin
      dec_dist  = distance;
      dec_run   = len;
      dec_trail = trail[1:0];
      dec_phase = lzo_pkg::PH_COPY;
    end
  endfunction

  function automatic void take_token(logic [7:0] b, lzo_pkg::phase_e ctx);
    int unsigned t;
    dec_token = b;
    if (b >= 64) begin
      dec_phase = lzo_pkg::PH_D1_M2;
    end else if (b >= 16) begin
      t = (b >= 32) ? (b & 31) : (b & 7);
      dec_run   = (t == 0) ? 0 : t + 2;
      dec_phase = (t == 0) ? lzo_pkg::PH_M_EXT : lzo_pkg::PH_D2_LO;
    end else if (ctx == lzo_pkg::PH_TOKEN_LIT) begin
      dec_phase = lzo_pkg::PH_D1_SHORT3;
    end else if (ctx == lzo_pkg::PH_TOKEN_MATCH) begin
      dec_phase = lzo_pkg::PH_D1_SHORT2;
    end else if (b == 0) begin
      dec_run   = 0;
      dec_phase = lzo_pkg::PH_LIT_EXT;
    end else begin
      open_literals(longint'(b) + 3);
    end
  endfunction

  function automatic void parse_stream_byte(logic [7:0] b, inout decoded_t r);
    int unsigned v;
    case (dec_phase)
      lzo_pkg::PH_FIRST: begin
        if (b > 17) begin
          if (b - 17 >= 4) open_literals(b - 17);
          else if (run_too_long(b - 17)) dec_outcome = lzo_pkg::ST_OVERRUN;
          else begin
            dec_trail = 2'(b - 17);
            dec_phase = lzo_pkg::PH_TRAIL;
          end
        end else begin
          take_token(b, lzo_pkg::PH_TOKEN);
        end
      end
      lzo_pkg::PH_TOKEN, lzo_pkg::PH_TOKEN_LIT, lzo_pkg::PH_TOKEN_MATCH:
        take_token(b, dec_phase);
      lzo_pkg::PH_LIT_EXT: begin
        if (b == 0) dec_run = sat_len(dec_run + 255);
        else open_literals(sat_len(dec_run + 18 + b));
      end
      lzo_pkg::PH_LITERALS: begin
        emit_byte(b, r);
        dec_run--;
        if (dec_run == 0) dec_phase = lzo_pkg::PH_TOKEN_LIT;
      end
      lzo_pkg::PH_TRAIL: begin
        emit_byte(b, r);
        dec_trail = dec_trail - 2'd1;
        if (dec_trail == 0) dec_phase = lzo_pkg::PH_TOKEN_MATCH;
      end
      lzo_pkg::PH_D1_M2:
        open_copy(1 + ((dec_token >> 2) & 7) + (b << 3), (dec_token >> 5) + 1, dec_token);
      lzo_pkg::PH_D1_SHORT2: open_copy(1 + (dec_token >> 2) + (b << 2), 2, dec_token);
      lzo_pkg::PH_D1_SHORT3:
        open_copy(32'h801 + (dec_token >> 2) + (b << 2), 3, dec_token);
      lzo_pkg::PH_M_EXT: begin
        if (b == 0) begin
          dec_run = sat_len(dec_run + 255);
        end else begin
          dec_run   = sat_len(dec_run + ((dec_token >= 32) ? 31 : 7) + b + 2);
          dec_phase = lzo_pkg::PH_D2_LO;
        end
      end
      lzo_pkg::PH_D2_LO: begin
        dec_dist  = b;
        dec_phase = lzo_pkg::PH_D2_HI;
      end
      lzo_pkg::PH_D2_HI: begin
        v = (dec_dist | (b << 8)) >> 2;
        if (dec_token >= 32)
          open_copy(1 + v, dec_run, 8'(dec_dist));
        else if ((dec_token & 8) == 0 && v == 0)
          dec_outcome = lzo_pkg::ST_DONE;
        else
          open_copy(32'h4000 + ((dec_token & 8) << 11) + v, dec_run, 8'(dec_dist));
      end
      default: ;
    endcase
  endfunction

  function automatic void drain_copy(inout decoded_t r);
    logic [31:0] src;
    src = dec_produced - dec_dist;
    emit_byte(dec_hist[src[15:0]], r);
    dec_run--;
    if (dec_run == 0) begin
      if (dec_trail == 0) dec_phase = lzo_pkg::PH_TOKEN;
      else if (run_too_long(dec_trail)) dec_outcome = lzo_pkg::ST_OVERRUN;
      else dec_phase = lzo_pkg::PH_TRAIL;
    end
  endfunction

  function automatic decoded_t decode_request(lzo_pkg::func_e fn, logic [7:0] b,
                                              logic last);
    decoded_t r;
    r = '0;
    if (dec_outcome != lzo_pkg::ST_RUNNING) begin
      if (fn == lzo_pkg::FN_BYTE &&
          (dec_outcome == lzo_pkg::ST_DONE || dec_outcome == lzo_pkg::ST_TRAILING))
        dec_outcome = lzo_pkg::ST_TRAILING;
    end else if (fn == lzo_pkg::FN_DRAIN) begin
      if (dec_phase == lzo_pkg::PH_COPY) drain_copy(r);
    end else if (dec_phase != lzo_pkg::PH_COPY) begin
      parse_stream_byte(b, r);
      if (last && dec_outcome == lzo_pkg::ST_RUNNING) dec_outcome = lzo_pkg::ST_SHORT;
    end
    r.status  = dec_outcome;
    r.pending = (dec_outcome == lzo_pkg::ST_RUNNING && dec_phase == lzo_pkg::PH_COPY);
    r.total   = dec_produced;
    return r;
  endfunction

  // Stream generator: picks bytes that keep the stream well formed
  function automatic logic [7:0] pick_upto(longint signed span);
    if (span < 0) return 8'd0;
    return 8'($urandom_range(0, span > 255 ? 255 : int'(span)));
  endfunction

  function automatic logic [7:0] pick_token();
    int unsigned r;
    r = $urandom_range(99);
    if (dec_phase == lzo_pkg::PH_TOKEN && r < 30)
      return ($urandom_range(24) == 0) ? 8'd0 : 8'($urandom_range(1, 15));
    if (dec_phase != lzo_pkg::PH_TOKEN && r < 30 &&
        (dec_phase == lzo_pkg::PH_TOKEN_MATCH || dec_produced >= 32'h805))
      return 8'($urandom_range(0, 15));
    if (r < 65) return 8'($urandom_range(64, 255));
    return 8'($urandom_range(32, 63));
  endfunction

  function automatic void next_stream_request(output lzo_pkg::func_e fn,
                                              output logic [7:0] b);
    int unsigned d;
    int unsigned v;
    fn = lzo_pkg::FN_BYTE;
    b  = 8'($urandom);
    case (dec_phase)
      lzo_pkg::PH_COPY: if ($urandom_range(9) != 0) fn = lzo_pkg::FN_DRAIN;
      lzo_pkg::PH_TOKEN, lzo_pkg::PH_TOKEN_LIT, lzo_pkg::PH_TOKEN_MATCH:
        b = pick_token();
      lzo_pkg::PH_LIT_EXT, lzo_pkg::PH_M_EXT:
        b = ($urandom_range(39) == 0) ? 8'd0 : 8'($urandom_range(1, 6));
      lzo_pkg::PH_D1_M2:
        b = pick_upto((longint'(dec_produced) - 1 - ((dec_token >> 2) & 7)) >>> 3);
      lzo_pkg::PH_D1_SHORT2:
        b = pick_upto((longint'(dec_produced) - 1 - (dec_token >> 2)) >>> 2);
      lzo_pkg::PH_D1_SHORT3:
        b = pick_upto((longint'(dec_produced) - 32'h801 - (dec_token >> 2)) >>> 2);
      lzo_pkg::PH_D2_LO: begin
        d = $urandom_range(1, dec_produced > 16384 ? 16384 : dec_produced);
        v = d - 1;
        b = 8'(((v & 63) << 2) | $urandom_range(3));
        planned_hi = 8'(v >> 6);
      end
      lzo_pkg::PH_D2_HI: b = planned_hi;
      default: ;
    endcase
  endfunction

  // Request side
  task automatic send_request(lzo_pkg::func_e fn, logic [7:0] b, logic last,
                              logic typed = 1'b0, decoded_t want = '0);
    decoded_t r;
    r = decode_request(fn, b, last);
    decoded_q.push_back(typed ? want : r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i     <= fn;
    in_byte_i  <= b;
    in_last_i  <= last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (decoded_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_limit(logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 3'(lzo_pkg::RegOutputLimit) << 2;
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    dec_limit = value;
  endtask

  // Result side: random stall
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk_i) begin
    decoded_t want;
    decoded_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{res_out_valid_o, out_byte_o, lzo_pkg::status_e'(status_o), copy_pending_o,
              produced_total_o};
      if (decoded_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
      end else begin
        want = decoded_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    int unsigned accepted;
    int unsigned ending;
    lzo_pkg::func_e fn;
    logic [7:0]  b;
    logic        ignored;
    logic [31:0] phase_limits [3];

    mismatches    = 0;
    cycles        = 0;
    send_idle_pct = 0;
    stall_pct     = 0;
    planned_hi    = 8'd0;
    rst_ni      = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    in_valid_i  = 1'b0;
    func_i      = lzo_pkg::FN_BYTE;
    in_byte_i   = '0;
    in_last_i   = 1'b0;
    out_stall_i = 1'b0;
    dec_limit    = 32'd65536;
    dec_produced = '0;
    dec_phase    = lzo_pkg::PH_FIRST;
    dec_run      = 0;
    dec_dist     = 0;
    dec_token    = '0;
    dec_trail    = '0;
    dec_outcome  = lzo_pkg::ST_RUNNING;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: one-byte trailing literal under a limit of one, then tokens
    write_limit(32'd1);
    foreach (head_rows[i])
      send_request(head_rows[i].fn, head_rows[i].data, head_rows[i].last,
                   head_rows[i].typed, head_rows[i].want);
    wait_idle();
    write_limit(32'hFFFF_FFFF);
    foreach (body_rows[i])
      send_request(body_rows[i].fn, body_rows[i].data, body_rows[i].last,
                   body_rows[i].typed, body_rows[i].want);

    // Random stream across the idling phases
    phase_limits[0] = 32'd65536;
    phase_limits[1] = 32'd20000;
    phase_limits[2] = 32'hFFFF_FFFF;
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 54; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 54; end
        default: begin send_idle_pct = 16; stall_pct = 16; end
      endcase
      if (p > 0) begin
        wait_idle();
        write_limit(p == 2 ? dec_produced + phase_limits[1] : phase_limits[p - 1]);
      end
      accepted = 0;
      while (accepted < ItemsPerPhase) begin
        next_stream_request(fn, b);
        ignored = (fn == lzo_pkg::FN_BYTE && dec_phase == lzo_pkg::PH_COPY);
        send_request(fn, b, 1'b0);
        if (!ignored) accepted++;
      end
    end

    // Bring the stream to a token boundary, then close it one of four ways
    while (!(dec_phase inside {lzo_pkg::PH_TOKEN, lzo_pkg::PH_TOKEN_LIT,
                               lzo_pkg::PH_TOKEN_MATCH})) begin
      next_stream_request(fn, b);
      send_request(fn, b, 1'b0);
    end
    ending = $urandom_range(3);
    case (ending)
      0: begin
        // end marker
        send_request(lzo_pkg::FN_BYTE, 8'h11, 1'b0);
        send_request(lzo_pkg::FN_BYTE, 8'h00, 1'b0);
        send_request(lzo_pkg::FN_BYTE, 8'h00, 1'b0);
      end
      1: begin
        // far distance beyond what was produced
        send_request(lzo_pkg::FN_BYTE, 8'h19, 1'b0);
        send_request(lzo_pkg::FN_BYTE, 8'h00, 1'b0);
        send_request(lzo_pkg::FN_BYTE, 8'h00, 1'b0);
      end
      2: begin
        // match longer than the room left under the limit
        wait_idle();
        write_limit(dec_produced + 32'd1);
        send_request(lzo_pkg::FN_BYTE, 8'h25, 1'b0);
        send_request(lzo_pkg::FN_BYTE, 8'h00, 1'b0);
        send_request(lzo_pkg::FN_BYTE, 8'h00, 1'b0);
      end
      default: send_request(lzo_pkg::FN_BYTE, 8'h40, 1'b1);
    endcase
    // Noise after the stream has stopped
    repeat (20)
      send_request(lzo_pkg::func_e'($urandom_range(1)), 8'($urandom),
                   1'($urandom_range(1)));

    in_valid_i <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
